@@ design/npp_pkg.sv @@
package npp_pkg;

	// Storage geometry
	localparam int DEPTH      = 16;
	localparam int VALUE_BITS = 8;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int PTR_W      = IDX_W + 1;

	// Port widths fixed by the interface
	localparam int CMD_W  = 2;
	localparam int SLOT_W = 4;
	localparam int DATA_W = 8;
	localparam int CFGI_W = 2;
	localparam int NL_W   = 8;
	localparam int ML_W   = 4;

	// Input commands
	localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

	// Configuration register indexes
	localparam logic [CFGI_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFGI_W-1:0] REG_N_LAST = 2'd1;
	localparam logic [CFGI_W-1:0] REG_M_LAST = 2'd2;

	// Modes
	localparam logic MODE_PERM = 1'b0;
	localparam logic MODE_REP  = 1'b1;

	// Datapath operations
	typedef logic [4:0] op_t;
	localparam op_t OP_NOP   = 5'd0;
	localparam op_t OP_LOAD  = 5'd1;
	localparam op_t OP_WRITE = 5'd2;
	localparam op_t OP_READ  = 5'd3;
	localparam op_t OP_EMIT  = 5'd4;
	localparam op_t OP_PLDM  = 5'd5;
	localparam op_t OP_PSCAN = 5'd6;
	localparam op_t OP_SWAP2 = 5'd7;
	localparam op_t OP_PV0   = 5'd8;
	localparam op_t OP_PV    = 5'd9;
	localparam op_t OP_RVA   = 5'd10;
	localparam op_t OP_RVB   = 5'd11;
	localparam op_t OP_RVC   = 5'd12;
	localparam op_t OP_Q0    = 5'd13;
	localparam op_t OP_QS    = 5'd14;
	localparam op_t OP_R2I   = 5'd15;
	localparam op_t OP_OI    = 5'd16;
	localparam op_t OP_OS    = 5'd17;
	localparam op_t OP_OC    = 5'd18;

	typedef logic [VALUE_BITS-1:0] val_t;

	typedef struct packed {
		op_t  op;
		logic set_adv;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             mode;
		logic             out_free;
		logic             a_gt_n;
		logic             gt;
		logic             lt;
		logic             ne;
		logic             a_zero;
		logic             n_zero;
		logic             lo_lt_hi;
		logic             clr_end;
	} dp_sts_t;

endpackage

@@ design/npp_dp.sv @@
module npp_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [npp_pkg::CFGI_W-1:0]    cfg_index,
	input  logic [npp_pkg::DATA_W-1:0]    cfg_data,
	input  logic [npp_pkg::CMD_W-1:0]     command,
	input  logic [npp_pkg::SLOT_W-1:0]    slot,
	input  logic [npp_pkg::DATA_W-1:0]    value,
	input  logic                          out_ready,
	input  npp_pkg::dp_cmd_t              cmd,
	output npp_pkg::dp_sts_t              sts,
	output logic                          out_valid,
	output logic [npp_pkg::DATA_W-1:0]    read_value,
	output logic                          advanced
);
	import npp_pkg::*;

	// Configuration
	logic            mode_q;
	logic [NL_W-1:0] n_last_q;
	logic [ML_W-1:0] m_last_q;

	// Latched item
	logic [CMD_W-1:0]  cmd_q;
	logic [SLOT_W-1:0] slot_q;
	logic [DATA_W-1:0] value_q;

	// Arrangement store
	val_t mem_q [DEPTH];

	// Work registers
	logic [PTR_W-1:0] a_q;
	logic [PTR_W-1:0] b_q;
	logic [IDX_W-1:0] piv_q;
	val_t             key_q;
	val_t             t_q;
	logic             adv_q;
	logic [DATA_W-1:0] rd_q;

	// Result register
	logic              out_valid_q;
	logic [DATA_W-1:0] read_value_q;
	logic              advanced_q;

	logic [IDX_W-1:0] n_eff;
	logic [IDX_W-1:0] m_eff;
	logic [IDX_W-1:0] m_rep;
	logic [IDX_W-1:0] start;
	logic [IDX_W-1:0] slot_idx;
	logic             slot_ok;
	logic [IDX_W-1:0] ra;
	val_t             rdata;
	logic             we;
	logic [IDX_W-1:0] wa;
	val_t             wd;

	// Clamp the configured bounds
	always_comb begin
		n_eff = (32'(n_last_q) > DEPTH - 1) ? IDX_W'(DEPTH - 1) : IDX_W'(n_last_q);
		m_eff = (32'(m_last_q) > 32'(n_eff)) ? n_eff : IDX_W'(m_last_q);
		m_rep = (32'(m_last_q) > DEPTH - 1) ? IDX_W'(DEPTH - 1) : IDX_W'(m_last_q);
		start = (m_eff < n_eff) ? m_eff : n_eff - IDX_W'(1);
		slot_idx = slot_q[IDX_W-1:0];
		slot_ok  = (32'(slot_q) < DEPTH);
	end

	// Select the single read address
	always_comb begin
		if (cmd.op == OP_READ)
			ra = slot_idx;
		else if (cmd.op == OP_PLDM)
			ra = m_eff;
		else if (cmd.op == OP_PV0)
			ra = n_eff;
		else if (cmd.op == OP_RVB)
			ra = b_q[IDX_W-1:0];
		else if (cmd.op inside {OP_PSCAN, OP_PV, OP_RVA, OP_QS, OP_OS})
			ra = a_q[IDX_W-1:0];
		else
			ra = '0;
		rdata = mem_q[ra];
	end

	// Status back to the controller
	always_comb begin
		sts.cmd      = cmd_q;
		sts.mode     = mode_q;
		sts.out_free = !out_valid_q || out_ready;
		sts.a_gt_n   = a_q > PTR_W'(n_eff);
		sts.gt       = rdata > key_q;
		sts.lt       = rdata < t_q;
		sts.ne       = 16'(rdata) != 16'(n_last_q);
		sts.a_zero   = a_q == '0;
		sts.n_zero   = n_eff == '0;
		sts.lo_lt_hi = a_q < b_q;
		sts.clr_end  = b_q > PTR_W'(m_rep);
	end

	// Single write port
	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = '0;
		case (cmd.op)
			OP_WRITE: begin
				we = slot_ok;
				wa = slot_idx;
				wd = VALUE_BITS'(value_q);
			end
			OP_PSCAN: begin
				we = !sts.a_gt_n && sts.gt;
				wa = m_eff;
				wd = rdata;
			end
			OP_SWAP2: begin
				we = 1'b1;
				wa = a_q[IDX_W-1:0];
				wd = key_q;
			end
			OP_RVB: begin
				we = 1'b1;
				wa = a_q[IDX_W-1:0];
				wd = rdata;
			end
			OP_RVC: begin
				we = 1'b1;
				wa = b_q[IDX_W-1:0];
				wd = t_q;
			end
			OP_QS: begin
				we = sts.gt;
				wa = piv_q;
				wd = rdata;
			end
			OP_OS: begin
				we = sts.ne;
				wa = a_q[IDX_W-1:0];
				wd = rdata + val_t'(1);
			end
			OP_OC: begin
				we = !sts.clr_end;
				wa = b_q[IDX_W-1:0];
				wd = '0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[wa] <= wd;
	end

	// Configuration and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_PERM;
			n_last_q    <= NL_W'(15);
			m_last_q    <= ML_W'(15);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:   mode_q   <= cfg_data[0];
					REG_N_LAST: n_last_q <= NL_W'(cfg_data);
					REG_M_LAST: m_last_q <= ML_W'(cfg_data);
					default:    mode_q   <= mode_q;
				endcase
			end
			if (cmd.op == OP_EMIT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Work registers
	always_ff @(posedge clk) begin
		if (cmd.set_adv)
			adv_q <= 1'b1;
		case (cmd.op)
			OP_LOAD: begin
				cmd_q   <= command;
				slot_q  <= slot;
				value_q <= value;
				adv_q   <= 1'b0;
				rd_q    <= '0;
			end
			OP_READ: begin
				rd_q <= slot_ok ? DATA_W'(rdata) : '0;
			end
			OP_EMIT: begin
				read_value_q <= rd_q;
				advanced_q   <= adv_q;
			end
			OP_PLDM: begin
				key_q <= rdata;
				a_q   <= PTR_W'(m_eff) + PTR_W'(1);
			end
			OP_PSCAN: begin
				if (!sts.a_gt_n && !sts.gt)
					a_q <= a_q + PTR_W'(1);
			end
			OP_PV0: begin
				t_q <= rdata;
				a_q <= PTR_W'(start);
			end
			OP_PV: begin
				if (sts.lt) begin
					piv_q <= a_q[IDX_W-1:0];
					key_q <= rdata;
					a_q   <= PTR_W'(m_eff) + PTR_W'(1);
					b_q   <= PTR_W'(n_eff);
				end else begin
					t_q <= rdata;
					a_q <= a_q - PTR_W'(1);
				end
			end
			OP_RVA: begin
				t_q <= rdata;
			end
			OP_RVC: begin
				a_q <= a_q + PTR_W'(1);
				b_q <= b_q - PTR_W'(1);
			end
			OP_Q0: begin
				a_q <= PTR_W'(n_eff);
			end
			OP_QS: begin
				if (!sts.gt)
					a_q <= a_q - PTR_W'(1);
			end
			OP_R2I: begin
				a_q <= PTR_W'(piv_q) + PTR_W'(1);
				b_q <= PTR_W'(n_eff);
			end
			OP_OI: begin
				a_q <= PTR_W'(m_rep);
			end
			OP_OS: begin
				if (sts.ne)
					b_q <= a_q + PTR_W'(1);
				else
					a_q <= a_q - PTR_W'(1);
			end
			OP_OC: begin
				if (!sts.clr_end)
					b_q <= b_q + PTR_W'(1);
			end
			default: begin
				t_q <= t_q;
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign advanced   = advanced_q;

endmodule

@@ design/npp_ctrl.sv @@
module npp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  npp_pkg::dp_sts_t sts,
	output npp_pkg::dp_cmd_t cmd
);
	import npp_pkg::*;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DISP  = 5'd1;
	localparam logic [4:0] S_WR    = 5'd2;
	localparam logic [4:0] S_RD    = 5'd3;
	localparam logic [4:0] S_FIN   = 5'd4;
	localparam logic [4:0] S_PLDM  = 5'd5;
	localparam logic [4:0] S_PSCAN = 5'd6;
	localparam logic [4:0] S_PSW2  = 5'd7;
	localparam logic [4:0] S_PV0   = 5'd8;
	localparam logic [4:0] S_PV    = 5'd9;
	localparam logic [4:0] S_R1A   = 5'd10;
	localparam logic [4:0] S_R1B   = 5'd11;
	localparam logic [4:0] S_R1C   = 5'd12;
	localparam logic [4:0] S_Q0    = 5'd13;
	localparam logic [4:0] S_QS    = 5'd14;
	localparam logic [4:0] S_QSW   = 5'd15;
	localparam logic [4:0] S_R2I   = 5'd16;
	localparam logic [4:0] S_R2A   = 5'd17;
	localparam logic [4:0] S_R2B   = 5'd18;
	localparam logic [4:0] S_R2C   = 5'd19;
	localparam logic [4:0] S_OI    = 5'd20;
	localparam logic [4:0] S_OS    = 5'd21;
	localparam logic [4:0] S_OC    = 5'd22;

	logic [4:0] state_q;
	logic [4:0] state_d;

	// Next state and datapath command
	always_comb begin
		state_d     = state_q;
		cmd.op      = OP_NOP;
		cmd.set_adv = 1'b0;
		in_ready    = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.cmd)
					CMD_WRITE:   state_d = S_WR;
					CMD_READ:    state_d = S_RD;
					CMD_ADVANCE: state_d = (sts.mode == MODE_REP) ? S_OI : S_PLDM;
					default:     state_d = S_FIN;
				endcase
			end
			S_WR: begin
				cmd.op  = OP_WRITE;
				state_d = S_FIN;
			end
			S_RD: begin
				cmd.op  = OP_READ;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.op  = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			// Look for a larger element in the tail to swap into the last prefix slot
			S_PLDM: begin
				cmd.op  = OP_PLDM;
				state_d = S_PSCAN;
			end
			S_PSCAN: begin
				cmd.op = OP_PSCAN;
				if (sts.a_gt_n)
					state_d = S_PV0;
				else if (sts.gt)
					state_d = S_PSW2;
			end
			S_PSW2: begin
				cmd.op      = OP_SWAP2;
				cmd.set_adv = 1'b1;
				state_d     = S_FIN;
			end
			// Search the pivot as if the tail were already reversed
			S_PV0: begin
				cmd.op  = OP_PV0;
				state_d = sts.n_zero ? S_FIN : S_PV;
			end
			S_PV: begin
				cmd.op = OP_PV;
				if (sts.lt)
					state_d = S_R1A;
				else if (sts.a_zero)
					state_d = S_FIN;
			end
			// Reverse the tail
			S_R1A: begin
				cmd.op  = OP_RVA;
				state_d = sts.lo_lt_hi ? S_R1B : S_Q0;
			end
			S_R1B: begin
				cmd.op  = OP_RVB;
				state_d = S_R1C;
			end
			S_R1C: begin
				cmd.op  = OP_RVC;
				state_d = S_R1A;
			end
			// Find the rightmost element above the pivot and swap
			S_Q0: begin
				cmd.op  = OP_Q0;
				state_d = S_QS;
			end
			S_QS: begin
				cmd.op = OP_QS;
				if (sts.gt)
					state_d = S_QSW;
			end
			S_QSW: begin
				cmd.op  = OP_SWAP2;
				state_d = S_R2I;
			end
			// Reverse everything right of the pivot
			S_R2I: begin
				cmd.op      = OP_R2I;
				cmd.set_adv = 1'b1;
				state_d     = S_R2A;
			end
			S_R2A: begin
				cmd.op  = OP_RVA;
				state_d = sts.lo_lt_hi ? S_R2B : S_FIN;
			end
			S_R2B: begin
				cmd.op  = OP_RVB;
				state_d = S_R2C;
			end
			S_R2C: begin
				cmd.op  = OP_RVC;
				state_d = S_R2A;
			end
			// Odometer: bump the rightmost non-maximal digit, then clear to its right
			S_OI: begin
				cmd.op  = OP_OI;
				state_d = S_OS;
			end
			S_OS: begin
				cmd.op = OP_OS;
				if (sts.ne) begin
					cmd.set_adv = 1'b1;
					state_d     = S_OC;
				end else if (sts.a_zero) begin
					state_d = S_FIN;
				end
			end
			S_OC: begin
				cmd.op = OP_OC;
				if (sts.clr_end)
					state_d = S_FIN;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

`ifndef SYNTHESIS
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DISP))
		else $error("accepted transfer not dispatched");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMIT) |-> sts.out_free)
		else $error("result emitted over a pending transfer");

	a_adv_only_advance: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_adv |-> (sts.cmd == CMD_ADVANCE))
		else $error("advanced flag set by a non-advance command");
`endif

endmodule

@@ design/next_partial_permutation.sv @@
// Channel | Signals                              | Direction
// in      | in_valid, in_ready, command/slot/value | item in
// out     | out_valid, out_ready, read_value/advanced | result out
// cfg     | cfg_we, cfg_index, cfg_data          | register write
//
// Write and read each pass through a slot access state before the result; cmd 3 goes straight to it.
// Advance walks the slot store through its single read and single write port:
// permutation mode scans, swaps and reverses runs of slots; odometer mode bumps and clears digits.
// A finished result waits in the output register; the next item is taken meanwhile.
// Asynchronous active-low reset loads the register defaults; slots are undefined
// until written.
module next_partial_permutation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [npp_pkg::CFGI_W-1:0]    cfg_index,
	input  logic [npp_pkg::DATA_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [npp_pkg::CMD_W-1:0]     command,
	input  logic [npp_pkg::SLOT_W-1:0]    slot,
	input  logic [npp_pkg::DATA_W-1:0]    value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [npp_pkg::DATA_W-1:0]    read_value,
	output logic                          advanced
);
	import npp_pkg::*;

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	// Sequence the work
	npp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (dp_sts),
		.cmd      (dp_cmd)
	);

	// Hold slots, registers and results
	npp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.command    (command),
		.slot       (slot),
		.value      (value),
		.out_ready  (out_ready),
		.cmd        (dp_cmd),
		.sts        (dp_sts),
		.out_valid  (out_valid),
		.read_value (read_value),
		.advanced   (advanced)
	);

endmodule

@@ sim/tb_next_partial_permutation.sv @@
`timescale 1ns / 1ps

module tb_next_partial_permutation;
	import npp_pkg::*;

	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
	localparam int QUIET_LIMIT = 5000;
	localparam int ITEM_TARGET = 1620;
	localparam int PHASE_B_AT  = 560;
	localparam int PHASE_C_AT  = 1120;

	typedef logic [DEPTH-1:0][VALUE_BITS-1:0] slot_file_t;

	typedef struct packed {
		logic [DATA_W-1:0] rd;
		logic              adv;
	} outcome_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

	typedef struct packed {
		row_kind_e          kind;
		logic [CFGI_W-1:0]  idx;
		logic [CMD_W-1:0]   cmd;
		logic [SLOT_W-1:0]  slot;
		logic [DATA_W-1:0]  data;
		logic               typed;
		logic [DATA_W-1:0]  rd;
		logic               adv;
	} row_t;

	localparam int NROWS = 25;

	// Directed walk: slot extremes, unused command, n of zero, single swap,
	// exhausted k-permutation, odometer at its end, digit above the maximum
	row_t directed_rows [0:NROWS-1] = '{
		'{ROW_ITEM, REG_MODE,   CMD_WRITE,   4'd0,  8'hFF, 1'b1, 8'h00, 1'b0},
		'{ROW_ITEM, REG_MODE,   CMD_READ,    4'd0,  8'h00, 1'b1, 8'hFF, 1'b0},
		'{ROW_ITEM, REG_MODE,   CMD_WRITE,   4'd15, 8'h00, 1'b1, 8'h00, 1'b0},
		'{ROW_ITEM, REG_MODE,   CMD_READ,    4'd15, 8'hFF, 1'b1, 8'h00, 1'b0},
		'{ROW_ITEM, REG_MODE,   CMD_WRITE,   4'd0,  8'h00, 1'b1, 8'h00, 1'b0},
		'{ROW_ITEM, REG_MODE,   CMD_WRITE,   4'd1,  8'h01, 1'b1, 8'h00, 1'b0},
		'{ROW_ITEM, REG_MODE,   CMD_NONE,    4'd15, 8'hFF, 1'b1, 8'h00, 1'b0},
		'{ROW_REG,  REG_N_LAST, CMD_WRITE,   4'd0,  8'd0,  1'b0, 8'h00, 1'b0},
		'{ROW_ITEM, REG_MODE,   CMD_ADVANCE, 4'd0,  8'h00, 1'b1, 8'h00, 1'b0},
		'{ROW_REG,  REG_N_LAST, CMD_WRITE,   4'd0,  8'd1,  1'b0, 8'h00, 1'b0},
		'{ROW_REG,  REG_M_LAST, CMD_WRITE,   4'd0,  8'd0,  1'b0, 8'h00, 1'b0},
		'{ROW_ITEM, REG_MODE,   CMD_ADVANCE, 4'd9,  8'h5A, 1'b1, 8'h00, 1'b1},
		'{ROW_ITEM, REG_MODE,   CMD_READ,    4'd0,  8'h00, 1'b1, 8'h01, 1'b0},
		'{ROW_ITEM, REG_MODE,   CMD_ADVANCE, 4'd0,  8'h00, 1'b1, 8'h00, 1'b0},
		'{ROW_REG,  REG_MODE,   CMD_WRITE,   4'd0,  8'd1,  1'b0, 8'h00, 1'b0},
		'{ROW_REG,  REG_N_LAST, CMD_WRITE,   4'd0,  8'd255, 1'b0, 8'h00, 1'b0},
		'{ROW_ITEM, REG_MODE,   CMD_WRITE,   4'd0,  8'hFE, 1'b1, 8'h00, 1'b0},
		'{ROW_ITEM, REG_MODE,   CMD_ADVANCE, 4'd0,  8'h00, 1'b1, 8'h00, 1'b1},
		'{ROW_ITEM, REG_MODE,   CMD_READ,    4'd0,  8'h00, 1'b1, 8'hFF, 1'b0},
		'{ROW_ITEM, REG_MODE,   CMD_ADVANCE, 4'd0,  8'h00, 1'b1, 8'h00, 1'b0},
		'{ROW_REG,  REG_N_LAST, CMD_WRITE,   4'd0,  8'd3,  1'b0, 8'h00, 1'b0},
		'{ROW_ITEM, REG_MODE,   CMD_WRITE,   4'd0,  8'hFF, 1'b1, 8'h00, 1'b0},
		'{ROW_ITEM, REG_MODE,   CMD_ADVANCE, 4'd0,  8'h00, 1'b1, 8'h00, 1'b1},
		'{ROW_ITEM, REG_MODE,   CMD_READ,    4'd0,  8'h00, 1'b1, 8'h00, 1'b0},
		'{ROW_ITEM, REG_MODE,   CMD_READ,    4'd1,  8'h00, 1'b0, 8'h00, 1'b0}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CFGI_W-1:0]   cfg_index = '0;
	logic [DATA_W-1:0]   cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [CMD_W-1:0]    command = '0;
	logic [SLOT_W-1:0]   slot = '0;
	logic [DATA_W-1:0]   value = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [DATA_W-1:0]   read_value;
	logic                advanced;

	// Predictor state
	slot_file_t   slot_image;
	logic         cfg_mode;
	logic [7:0]   cfg_n_last;
	logic [3:0]   cfg_m_last;
	outcome_t     pending_outcomes[$];

	int send_idle = 35;
	int recv_idle = 57;
	int items_sent = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	next_partial_permutation DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.slot       (slot),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_value (read_value),
		.advanced   (advanced)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Reverse slots lo..hi
	function automatic slot_file_t flip(slot_file_t w, int lo, int hi);
		val_t t;
		while (lo < hi) begin
			t = w[lo];
			w[lo] = w[hi];
			w[hi] = t;
			lo++;
			hi--;
		end
		return w;
	endfunction

	// Step the k-permutation in slots 0..m over the pool 0..n
	function automatic logic perm_successor();
		slot_file_t w;
		int n, m, p, q, start, pivot;
		val_t t;
		logic found;
		n = (int'(cfg_n_last) > DEPTH - 1) ? DEPTH - 1 : int'(cfg_n_last);
		m = (int'(cfg_m_last) > n) ? n : int'(cfg_m_last);
		w = slot_image;
		found = 1'b0;
		// swap slot m with the first larger unused element
		for (p = m + 1; p <= n && !found; p++) begin
			if (w[p] > w[m]) begin
				t = w[p];
				w[p] = w[m];
				w[m] = t;
				found = 1'b1;
			end
		end
		if (found) begin
			slot_image = w;
			return 1'b1;
		end
		// otherwise restore the suffix order and run a full next-permutation
		w = flip(w, m + 1, n);
		start = (m < n) ? m : n - 1;
		pivot = -1;
		for (p = start; p >= 0 && pivot < 0; p--) begin
			if (w[p] < w[p + 1])
				pivot = p;
		end
		if (pivot < 0)
			return 1'b0;
		q = n;
		while (q > pivot && w[q] <= w[pivot])
			q--;
		t = w[q];
		w[q] = w[pivot];
		w[pivot] = t;
		slot_image = flip(w, pivot + 1, n);
		return 1'b1;
	endfunction

	// Step the odometer in slots 0..m with digits 0..n_last
	function automatic logic odometer_successor();
		int m, i;
		logic any;
		m = (int'(cfg_m_last) > DEPTH - 1) ? DEPTH - 1 : int'(cfg_m_last);
		any = 1'b0;
		for (i = 0; i <= m; i++) begin
			if (slot_image[i] != cfg_n_last)
				any = 1'b1;
		end
		if (!any)
			return 1'b0;
		i = m;
		while (i >= 0 && slot_image[i] == cfg_n_last) begin
			slot_image[i] = '0;
			i--;
		end
		slot_image[i] = slot_image[i] + 1'b1;
		return 1'b1;
	endfunction

	function automatic void predict_step(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
			input logic [DATA_W-1:0] d, output logic [DATA_W-1:0] rd, output logic adv);
		rd = '0;
		adv = 1'b0;
		case (c)
			CMD_WRITE: slot_image[s] = d[VALUE_BITS-1:0];
			CMD_READ: rd = DATA_W'(slot_image[s]);
			CMD_ADVANCE: adv = (cfg_mode == MODE_REP) ? odometer_successor() : perm_successor();
			default: ;
		endcase
	endfunction

	// Present one item, hold it until transfer, then log its outcome
	task automatic send_item(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
			input logic [DATA_W-1:0] d, input logic typed, input logic [DATA_W-1:0] rd,
			input logic adv);
		logic [DATA_W-1:0] p_rd;
		logic p_adv;
		if (items_sent == PHASE_B_AT) begin
			send_idle = 57;
			recv_idle = 35;
		end else if (items_sent == PHASE_C_AT) begin
			send_idle = 0;
			recv_idle = 0;
		end
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		slot <= s;
		value <= d;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_step(c, s, d, p_rd, p_adv);
		if (typed) begin
			p_rd = rd;
			p_adv = adv;
		end
		pending_outcomes.push_back('{p_rd, p_adv});
		items_sent++;
	endtask

	// Drop valid and hold until every outcome has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		case (idx)
			REG_MODE: cfg_mode = d[0];
			REG_N_LAST: cfg_n_last = d;
			REG_M_LAST: cfg_m_last = d[3:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// One setting: configure, load all slots, then a burst of mostly advances
	task automatic run_segment();
		int vals [DEPTH];
		int r, k, j, tmp, burst, shape;
		logic md;
		logic [7:0] nl;
		logic [3:0] ml;
		drain();
		md = 1'($urandom_range(1));
		if (md == MODE_PERM) begin
			r = $urandom_range(9);
			nl = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : (r == 2) ? 8'd15 :
				8'($urandom_range(1, 5));
			r = $urandom_range(4);
			ml = (r == 0) ? 4'd0 : (r == 1) ? 4'd15 :
				4'($urandom_range(0, (nl > 15) ? 15 : int'(nl)));
		end else begin
			r = $urandom_range(9);
			nl = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(1, 3));
			r = $urandom_range(9);
			ml = (r == 0) ? 4'd0 : (r == 1) ? 4'd15 : 4'($urandom_range(1, 3));
		end
		write_reg(REG_MODE, {7'd0, md});
		write_reg(REG_N_LAST, nl);
		write_reg(REG_M_LAST, {4'd0, ml});

		// build the starting arrangement
		shape = $urandom_range(9);
		if (md == MODE_PERM && shape < 8) begin
			vals[0] = $urandom_range(15);
			for (k = 1; k < DEPTH; k++)
				vals[k] = vals[k - 1] + $urandom_range(1, 15);
			if (shape >= 5) begin
				for (k = DEPTH - 1; k > 0; k--) begin
					j = $urandom_range(k);
					tmp = vals[k];
					vals[k] = vals[j];
					vals[j] = tmp;
				end
			end
		end else begin
			for (k = 0; k < DEPTH; k++) begin
				if (md == MODE_PERM)
					vals[k] = $urandom_range(3);
				else if ($urandom_range(99) < 85)
					vals[k] = $urandom_range(int'(nl));
				else
					vals[k] = $urandom_range(255);
			end
		end
		for (k = 0; k < DEPTH; k++)
			send_item(CMD_WRITE, SLOT_W'(k), DATA_W'(vals[k]), 1'b0, '0, 1'b0);

		burst = $urandom_range(20, 70);
		for (k = 0; k < burst; k++) begin
			r = $urandom_range(99);
			send_item((r < 72) ? CMD_ADVANCE : (r < 87) ? CMD_READ : (r < 94) ? CMD_WRITE :
				CMD_NONE, SLOT_W'($urandom_range(15)), DATA_W'($urandom_range(255)),
				1'b0, '0, 1'b0);
		end
	endtask

	// Check each result transfer and randomize the receiver stall
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_outcomes.size() == 0) begin
				$error("result with none outstanding: read_value %0h advanced %0b",
					read_value, advanced);
				mismatches++;
			end else begin
				want = pending_outcomes.pop_front();
				if (read_value !== want.rd) begin
					$error("read_value: expected %0h, got %0h", want.rd, read_value);
					mismatches++;
				end
				if (advanced !== want.adv) begin
					$error("advanced: expected %0b, got %0b", want.adv, advanced);
					mismatches++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// Watchdog: end the run if no transfer happens for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int i;
		slot_image = '0;
		cfg_mode = MODE_PERM;
		cfg_n_last = 8'd15;
		cfg_m_last = 4'd15;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < NROWS; i++) begin
			if (directed_rows[i].kind == ROW_REG) begin
				drain();
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				send_item(directed_rows[i].cmd, directed_rows[i].slot, directed_rows[i].data,
					directed_rows[i].typed, directed_rows[i].rd, directed_rows[i].adv);
			end
		end

		while (items_sent < ITEM_TARGET)
			run_segment();

		drain();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending_outcomes.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
